// ===== rtl/core/lkc_pkg.sv =====
// shared constants, types and codes for the keyed lru cache
// no dependencies; compiled first

package lkc_pkg;

	localparam int ENTRIES  = 16;
	localparam int DATA_W   = 32;
	localparam int KEY_W    = 64;
	localparam int WORD_W   = 32;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int CNT_W    = $clog2(ENTRIES + 1);
	localparam int STAT_W   = 32;

	typedef enum logic [1:0] {
		ACT_PUT   = 2'd0,
		ACT_GET   = 2'd1,
		ACT_INV   = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef logic [ENTRIES-1:0][KEY_W-1:0]  key_arr_t;
	typedef logic [ENTRIES-1:0][IDX_W-1:0]  rank_arr_t;

	// result of the parallel tag search
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic [IDX_W-1:0] hit_rank;
		logic [IDX_W-1:0] free_idx;
		logic [IDX_W-1:0] lru_idx;
	} lookup_t;

	// statistic events for one beat
	typedef struct packed {
		logic get_hit;
		logic get_miss;
		logic evict;
	} stat_ev_t;

endpackage

// ===== rtl/core/lkc_if.sv =====
// request and response channel interfaces of the keyed lru cache
// depends on lkc_pkg

interface lkc_req_if;
	logic                      valid;
	logic                      ready;
	lkc_pkg::action_t          action;
	logic [lkc_pkg::KEY_W-1:0] key;
	logic [lkc_pkg::WORD_W-1:0] data_in;

	modport source (output valid, action, key, data_in, input ready);
	modport sink   (input valid, action, key, data_in, output ready);
endinterface

interface lkc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [lkc_pkg::WORD_W-1:0]  read_data;
	logic                        evicted;
	logic [lkc_pkg::CNT_W-1:0]   occupancy;
	logic [lkc_pkg::STAT_W-1:0]  hit_count;
	logic [lkc_pkg::STAT_W-1:0]  miss_count;
	logic [lkc_pkg::STAT_W-1:0]  eviction_count;

	modport source (output valid, hit, read_data, evicted, occupancy, hit_count, miss_count,
		eviction_count, input ready);
	modport sink   (input valid, hit, read_data, evicted, occupancy, hit_count, miss_count,
		eviction_count, output ready);
endinterface

// ===== rtl/core/lru_keyed_cache_top.sv =====
// top level of the fully associative keyed lru cache
// depends on lkc_pkg, lkc_if, lkc_lookup, lkc_slots, lkc_stats

// Fully associative cache of 16 slots, each a 64-bit key and a 32-bit data word, kept in
// least-recently-used order. Every request beat carries one action: put writes or inserts a
// key as most recent (replacing the least recent slot when all slots are valid), get returns
// the stored word on a hit and promotes the slot, invalidate drops a key, clear empties all
// slots while the statistics survive. Each request gives exactly one response beat with the
// hit flag, read data (zero unless a get hit), eviction flag, occupancy after the action and
// the three saturating statistics counters as they stand after it. Throughput is one beat per
// cycle while the response side takes each beat; a request passes the request register, then the
// response register. The step between them is bounded by the 16-way parallel 64-bit key compare
// feeding the rank update of every slot. Inserts go to the lowest-numbered free slot. Stored
// keys and data have no reset; the valid bits, ranks, occupancy and counters are cleared by
// arst_n. Backpressure on the response side stalls the request register, so a new request is
// still taken while a finished response waits, as long as the request register is empty.

module lru_keyed_cache_top (
	input  logic         clk,
	input  logic         arst_n,
	lkc_req_if.sink      req,
	lkc_rsp_if.source    rsp
);

	// request register
	logic                           valid_s1;
	lkc_pkg::action_t               action_s1;
	logic [lkc_pkg::KEY_W-1:0]      key_s1;
	logic [lkc_pkg::WORD_W-1:0]     data_s1;

	// response register
	logic                           rsp_valid_q;
	logic                           hit_q;
	logic                           evicted_q;
	logic [lkc_pkg::WORD_W-1:0]     rdata_q;

	logic                           advance;
	logic [lkc_pkg::ENTRIES-1:0]    valid;
	lkc_pkg::key_arr_t              keys;
	lkc_pkg::rank_arr_t             ranks;
	logic [lkc_pkg::CNT_W-1:0]      occ;
	logic                           full;
	logic [lkc_pkg::DATA_W-1:0]     rdata;
	lkc_pkg::lookup_t               lkup;
	lkc_pkg::stat_ev_t              ev;
	logic                           is_clear;
	logic                           is_get;

	// the slot state moves only when the beat in s1 can land in the response register
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			key_s1    <= req.key;
			data_s1   <= req.data_in;
		end
	end

	lkc_lookup u_lookup (
		.key   (key_s1),
		.valid (valid),
		.keys  (keys),
		.ranks (ranks),
		.lkup  (lkup)
	);

	lkc_slots u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.action (action_s1),
		.key    (key_s1),
		.data   (data_s1[lkc_pkg::DATA_W-1:0]),
		.lkup   (lkup),
		.valid  (valid),
		.keys   (keys),
		.ranks  (ranks),
		.occ    (occ),
		.full   (full),
		.rdata  (rdata)
	);

	assign is_clear = (action_s1 == lkc_pkg::ACT_CLEAR);
	assign is_get   = (action_s1 == lkc_pkg::ACT_GET);

	always_comb begin
		ev          = '0;
		ev.get_hit  = advance && is_get && lkup.hit;
		ev.get_miss = advance && is_get && !lkup.hit;
		// a put of a new key into a full cache pushes out the least recent slot
		ev.evict    = advance && (action_s1 == lkc_pkg::ACT_PUT) && !lkup.hit && full;
	end

	lkc_stats u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev        (ev),
		.hit_cnt   (rsp.hit_count),
		.miss_cnt  (rsp.miss_count),
		.evict_cnt (rsp.eviction_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q     <= lkup.hit && !is_clear;
			evicted_q <= ev.evict;
			rdata_q   <= (is_get && lkup.hit) ? lkc_pkg::WORD_W'(rdata) : '0;
		end
	end

	// counters and occupancy update on the same edge as the response register,
	// and cannot move again until this response is taken
	assign rsp.valid     = rsp_valid_q;
	assign rsp.hit       = hit_q;
	assign rsp.evicted   = evicted_q;
	assign rsp.read_data = rdata_q;
	assign rsp.occupancy = occ;

endmodule

// ===== rtl/core/lkc_lookup.sv =====
// parallel key compare, free slot and lru slot search
// depends on lkc_pkg

module lkc_lookup (
	input  logic [lkc_pkg::KEY_W-1:0]   key,
	input  logic [lkc_pkg::ENTRIES-1:0] valid,
	input  lkc_pkg::key_arr_t           keys,
	input  lkc_pkg::rank_arr_t          ranks,
	output lkc_pkg::lookup_t            lkup
);

	always_comb begin
		lkup = '0;
		// scan downward so the lowest matching slot wins
		for (int i = lkc_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (valid[i] && keys[i] == key) begin
				lkup.hit      = 1'b1;
				lkup.hit_idx  = lkc_pkg::IDX_W'(i);
				lkup.hit_rank = ranks[i];
			end
			if (!valid[i]) begin
				lkup.free_idx = lkc_pkg::IDX_W'(i);
			end
			if (valid[i] && ranks[i] == lkc_pkg::IDX_W'(lkc_pkg::ENTRIES - 1)) begin
				lkup.lru_idx = lkc_pkg::IDX_W'(i);
			end
		end
	end

endmodule

// ===== rtl/core/lkc_slots.sv =====
// slot storage: keys, data, valid bits, recency ranks and fill count
// depends on lkc_pkg

module lkc_slots (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  lkc_pkg::action_t             action,
	input  logic [lkc_pkg::KEY_W-1:0]    key,
	input  logic [lkc_pkg::DATA_W-1:0]   data,
	input  lkc_pkg::lookup_t             lkup,
	output logic [lkc_pkg::ENTRIES-1:0]  valid,
	output lkc_pkg::key_arr_t            keys,
	output lkc_pkg::rank_arr_t           ranks,
	output logic [lkc_pkg::CNT_W-1:0]    occ,
	output logic                         full,
	output logic [lkc_pkg::DATA_W-1:0]   rdata
);

	logic [lkc_pkg::ENTRIES-1:0]              valid_q, valid_d;
	lkc_pkg::rank_arr_t                       rank_q, rank_d;
	lkc_pkg::key_arr_t                        key_q;
	logic [lkc_pkg::ENTRIES-1:0][lkc_pkg::DATA_W-1:0] data_q;
	logic [lkc_pkg::CNT_W-1:0]                occ_q, occ_d;
	logic                                     do_promote, do_remove, do_clear, do_write;
	logic [lkc_pkg::IDX_W-1:0]                tgt;
	logic [lkc_pkg::CNT_W-1:0]                pivot;

	assign full = (occ_q == lkc_pkg::CNT_W'(lkc_pkg::ENTRIES));

	always_comb begin
		do_promote = 1'b0;
		do_remove  = 1'b0;
		do_clear   = 1'b0;
		do_write   = 1'b0;
		tgt        = lkup.hit_idx;
		pivot      = {1'b0, lkup.hit_rank};
		occ_d      = occ_q;
		case (action)
			lkc_pkg::ACT_PUT: begin
				do_promote = 1'b1;
				do_write   = 1'b1;
				if (!lkup.hit) begin
					// new key goes above every valid rank
					pivot = occ_q;
					if (full) begin
						tgt = lkup.lru_idx;
					end else begin
						tgt   = lkup.free_idx;
						occ_d = occ_q + 1'b1;
					end
				end
			end
			lkc_pkg::ACT_GET: begin
				do_promote = lkup.hit;
			end
			lkc_pkg::ACT_INV: begin
				do_remove = lkup.hit;
				if (lkup.hit) begin
					occ_d = occ_q - 1'b1;
				end
			end
			lkc_pkg::ACT_CLEAR: begin
				do_clear = 1'b1;
				occ_d    = '0;
			end
			default: begin
				do_clear = 1'b0;
			end
		endcase
	end

	always_comb begin
		valid_d = valid_q;
		rank_d  = rank_q;
		for (int i = 0; i < lkc_pkg::ENTRIES; i++) begin
			if (do_clear) begin
				valid_d[i] = 1'b0;
				rank_d[i]  = '0;
			end else if (do_promote) begin
				if (lkc_pkg::IDX_W'(i) == tgt) begin
					valid_d[i] = 1'b1;
					rank_d[i]  = '0;
				end else if (valid_q[i] && {1'b0, rank_q[i]} < pivot) begin
					rank_d[i] = rank_q[i] + 1'b1;
				end
			end else if (do_remove) begin
				if (lkc_pkg::IDX_W'(i) == tgt) begin
					valid_d[i] = 1'b0;
					rank_d[i]  = '0;
				end else if (valid_q[i] && rank_q[i] > lkup.hit_rank) begin
					rank_d[i] = rank_q[i] - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rank_q  <= '0;
			occ_q   <= '0;
		end else if (en) begin
			valid_q <= valid_d;
			rank_q  <= rank_d;
			occ_q   <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en && do_write) begin
			key_q[tgt]  <= key;
			data_q[tgt] <= data;
		end
	end

	assign valid = valid_q;
	assign keys  = key_q;
	assign ranks = rank_q;
	assign occ   = occ_q;
	assign rdata = data_q[lkup.hit_idx];

endmodule

// ===== rtl/core/lkc_stats.sv =====
// saturating hit, miss and eviction counters
// depends on lkc_pkg

module lkc_stats (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lkc_pkg::stat_ev_t           ev,
	output logic [lkc_pkg::STAT_W-1:0]  hit_cnt,
	output logic [lkc_pkg::STAT_W-1:0]  miss_cnt,
	output logic [lkc_pkg::STAT_W-1:0]  evict_cnt
);

	logic [lkc_pkg::STAT_W-1:0] hit_q, miss_q, evict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= '0;
			miss_q  <= '0;
			evict_q <= '0;
		end else begin
			if (ev.get_hit && hit_q != '1) begin
				hit_q <= hit_q + 1'b1;
			end
			if (ev.get_miss && miss_q != '1) begin
				miss_q <= miss_q + 1'b1;
			end
			if (ev.evict && evict_q != '1) begin
				evict_q <= evict_q + 1'b1;
			end
		end
	end

	assign hit_cnt   = hit_q;
	assign miss_cnt  = miss_q;
	assign evict_cnt = evict_q;

endmodule

// ===== tb/lkc_checker.sv =====
`timescale 1ns / 100ps
// response checker for the keyed lru cache: watches the request and response channels,
// predicts every response beat and compares it field by field; depends on lkc_pkg and lkc_if

module lkc_checker
	import lkc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	lkc_req_if   req,
	lkc_rsp_if   rsp,
	output int   fail_count,
	output int   open_count
);

	typedef struct packed {
		logic              hit;
		logic [WORD_W-1:0] read_data;
		logic              evicted;
		logic [CNT_W-1:0]  occupancy;
		logic [STAT_W-1:0] hit_count;
		logic [STAT_W-1:0] miss_count;
		logic [STAT_W-1:0] eviction_count;
	} cache_rsp_t;

	cache_rsp_t        rsp_expected[$];
	logic [KEY_W-1:0]  slot_key  [ENTRIES];
	logic [DATA_W-1:0] slot_word [ENTRIES];
	bit                slot_live [ENTRIES];
	int unsigned       slot_age  [ENTRIES];
	bit [STAT_W-1:0]   hits_seen;
	bit [STAT_W-1:0]   misses_seen;
	bit [STAT_W-1:0]   evicts_seen;
	int                fails;

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			slot_live[i] = 1'b0;
			slot_age[i]  = 0;
		end
		hits_seen   = '0;
		misses_seen = '0;
		evicts_seen = '0;
		fails       = 0;
	end

	function automatic bit [STAT_W-1:0] sat_bump(bit [STAT_W-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	function automatic int find_slot(logic [KEY_W-1:0] k);
		for (int i = 0; i < ENTRIES; i++)
			if (slot_live[i] && slot_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic int live_count();
		int n;
		n = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (slot_live[i])
				n++;
		return n;
	endfunction

	// entries younger than s age by one, s becomes the newest
	function automatic void make_newest(int s);
		int unsigned r;
		r = slot_age[s];
		for (int i = 0; i < ENTRIES; i++)
			if (slot_live[i] && i != s && slot_age[i] < r)
				slot_age[i]++;
		slot_age[s] = 0;
	endfunction

	// free slot s and close the gap in the ages
	function automatic void drop_slot(int s);
		int unsigned r;
		r = slot_age[s];
		slot_live[s] = 1'b0;
		slot_age[s]  = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (slot_live[i] && slot_age[i] > r)
				slot_age[i]--;
	endfunction

	function automatic cache_rsp_t apply_action(action_t act, logic [KEY_W-1:0] k,
			logic [WORD_W-1:0] d);
		cache_rsp_t r;
		int s;
		int victim;
		int free_slot;
		r = '0;
		if (act == ACT_CLEAR) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_live[i] = 1'b0;
				slot_age[i]  = 0;
			end
		end else begin
			s = find_slot(k);
			r.hit = (s >= 0);
			case (act)
			ACT_PUT: begin
				if (s >= 0) begin
					slot_word[s] = DATA_W'(d);
					make_newest(s);
				end else begin
					if (live_count() >= ENTRIES) begin
						victim = -1;
						for (int i = 0; i < ENTRIES; i++)
							if (slot_live[i] && slot_age[i] == ENTRIES - 1)
								victim = i;
						if (victim >= 0)
							drop_slot(victim);
						r.evicted   = 1'b1;
						evicts_seen = sat_bump(evicts_seen);
					end
					// lowest-numbered free slot takes the new key
					free_slot = -1;
					for (int i = ENTRIES - 1; i >= 0; i--)
						if (!slot_live[i])
							free_slot = i;
					if (free_slot >= 0) begin
						for (int i = 0; i < ENTRIES; i++)
							if (slot_live[i])
								slot_age[i]++;
						slot_live[free_slot] = 1'b1;
						slot_key[free_slot]  = k;
						slot_word[free_slot] = DATA_W'(d);
						slot_age[free_slot]  = 0;
					end
				end
			end
			ACT_GET: begin
				if (s >= 0) begin
					r.read_data = WORD_W'(slot_word[s]);
					make_newest(s);
					hits_seen = sat_bump(hits_seen);
				end else begin
					misses_seen = sat_bump(misses_seen);
				end
			end
			default: begin
				if (s >= 0)
					drop_slot(s);
			end
			endcase
		end
		r.occupancy      = CNT_W'(live_count());
		r.hit_count      = hits_seen;
		r.miss_count     = misses_seen;
		r.eviction_count = evicts_seen;
		return r;
	endfunction

	task automatic check_field(string name, logic [STAT_W-1:0] want, logic [STAT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin : watch
		cache_rsp_t got;
		cache_rsp_t want;
		if (arst_n) begin
			// response first: it can never belong to a request taken on the same edge
			if (rsp.valid && rsp.ready) begin
				got.hit            = rsp.hit;
				got.read_data      = rsp.read_data;
				got.evicted        = rsp.evicted;
				got.occupancy      = rsp.occupancy;
				got.hit_count      = rsp.hit_count;
				got.miss_count     = rsp.miss_count;
				got.eviction_count = rsp.eviction_count;
				if (rsp_expected.size() == 0) begin
					$error("response beat with no request outstanding");
					fails++;
				end else begin
					want = rsp_expected.pop_front();
					check_field("hit", STAT_W'(want.hit), STAT_W'(got.hit));
					check_field("read_data", STAT_W'(want.read_data), STAT_W'(got.read_data));
					check_field("evicted", STAT_W'(want.evicted), STAT_W'(got.evicted));
					check_field("occupancy", STAT_W'(want.occupancy), STAT_W'(got.occupancy));
					check_field("hit_count", want.hit_count, got.hit_count);
					check_field("miss_count", want.miss_count, got.miss_count);
					check_field("eviction_count", want.eviction_count, got.eviction_count);
				end
			end
			if (req.valid && req.ready)
				rsp_expected.push_back(apply_action(req.action, req.key, req.data_in));
		end
		fail_count <= fails;
		open_count <= rsp_expected.size();
	end

endmodule

// ===== tb/lru_keyed_cache_top_tb.sv =====
`timescale 1ns / 100ps
// top of the keyed lru cache testbench: clock, reset, request stimulus, response stalls
// and the verdict; depends on lkc_pkg, lkc_if, lkc_checker and lru_keyed_cache_top

module lru_keyed_cache_top_tb;
	import lkc_pkg::*;

	localparam int ITEMS_TARGET = 950;
	// far above the slowest honest run (sender gaps, 30% ready, long holds)
	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 80;
	localparam int POOL_SIZE    = 64;
	localparam int TAIL_CYCLES  = 8;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	lkc_req_if req_ch ();
	lkc_rsp_if rsp_ch ();

	int fail_count;
	int open_count;
	int cycle_count = 0;
	int items_sent  = 0;
	// long receiver hold: stimulus bumps the request count, receiver serves it
	int hold_asked  = 0;
	int hold_served = 0;

	// keys are mostly drawn from a small pool so gets and puts hit often
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int pool_span;
	int put_pct;

	lru_keyed_cache_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	lkc_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	always #1 clk = ~clk;

	// hard stop in case a beat never gets through
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("lru_keyed_cache_top_tb failed");
			$finish;
		end
	end

	// offer one request beat and hold it until the block takes it
	task automatic send_item(action_t act, logic [KEY_W-1:0] k, logic [WORD_W-1:0] d);
		req_ch.valid   <= 1'b1;
		req_ch.action  <= act;
		req_ch.key     <= k;
		req_ch.data_in <= d;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// sender gap; zero means the next beat follows back to back
	task automatic idle_for(int n);
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stop offering and wait until every predicted response beat has come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		// wait so the checker has counted the last request
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		// now and then a fresh random key, which almost surely misses
		if ($urandom_range(0, 19) == 0)
			return {$urandom, $urandom};
		return key_pool[$urandom_range(0, pool_span - 1)];
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
		0:       return '0;
		1:       return '1;
		default: return $urandom;
		endcase
	endfunction

	function automatic action_t pick_action();
		int r;
		r = $urandom_range(0, 99);
		if (r < put_pct)
			return ACT_PUT;
		if (r < put_pct + 35)
			return ACT_GET;
		if (r < 98)
			return ACT_INV;
		// clear stays rare so the cache spends most of its time full
		return ACT_CLEAR;
	endfunction

	// receiver: stall pattern is redrawn after each random-length run, with a long hold on request
	initial begin : receiver
		int mode;
		int left;
		int tick;
		mode = 0;
		left = 0;
		tick = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_asked != hold_served) begin
				// long hold-off so the request side backs up and stalls
				hold_served = hold_asked;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(16, 96);
				end
				left--;
				tick++;
				case (mode)
				0:       rsp_ch.ready <= 1'b1;
				1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				2:       rsp_ch.ready <= ($urandom_range(0, 9) < 3);
				default: rsp_ch.ready <= ((tick % 5) < 2);
				endcase
			end
		end
	end

	initial begin : stimulus
		int phase;
		int quota;
		int burst;
		req_ch.valid   <= 1'b0;
		req_ch.action  <= ACT_PUT;
		req_ch.key     <= '0;
		req_ch.data_in <= '0;

		// pool: key extremes up front, the rest random
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = {1'b1, {(KEY_W - 1){1'b0}}};
		key_pool[3] = KEY_W'(1);
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = {$urandom, $urandom};
		pool_span = POOL_SIZE;
		put_pct   = 40;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: get on an empty cache misses
		send_item(ACT_GET, key_pool[0], '0);
		// extreme keys and data
		send_item(ACT_PUT, key_pool[0], '0);
		send_item(ACT_PUT, key_pool[1], '1);
		send_item(ACT_GET, key_pool[1], '0);
		// put on a present key replaces the data only
		send_item(ACT_PUT, key_pool[0], 32'hA5A5_5A5A);
		// invalidate present, then the same key again now absent
		send_item(ACT_INV, key_pool[1], '0);
		send_item(ACT_INV, key_pool[1], '1);
		// fill up to all slots valid; key 0 is the oldest
		for (int i = 4; i < 4 + ENTRIES - 1; i++)
			send_item(ACT_PUT, key_pool[i], $urandom);
		// promote key 0 so the first fill key becomes the least recent
		send_item(ACT_GET, key_pool[0], '0);
		// put on a full cache evicts the least recent entry
		send_item(ACT_PUT, key_pool[2], '1);
		send_item(ACT_GET, key_pool[4], '0);
		// clear empties everything but keeps the counters
		send_item(ACT_CLEAR, key_pool[3], '1);
		send_item(ACT_GET, key_pool[0], '0);
		drain();

		// random phases with varying key pool and action mix
		phase = 0;
		while (items_sent < ITEMS_TARGET) begin
			case ($urandom_range(0, 5))
			0:       pool_span = 3;
			1:       pool_span = 12;
			2:       pool_span = ENTRIES;
			3:       pool_span = ENTRIES + 1;
			4:       pool_span = 24;
			default: pool_span = POOL_SIZE;
			endcase
			put_pct = $urandom_range(30, 55);
			// ask for a long receiver hold while this phase keeps offering beats
			if (phase == 1 || phase == 5)
				hold_asked <= hold_asked + 1;
			quota = $urandom_range(50, 110);
			// keep the total close to the target
			if (quota > ITEMS_TARGET - items_sent)
				quota = ITEMS_TARGET - items_sent;
			while (quota > 0) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst && quota > 0; b++) begin
					send_item(pick_action(), pick_key(), pick_word());
					quota--;
				end
				if ($urandom_range(0, 3) == 0)
					idle_for(0);
				else
					idle_for($urandom_range(1, 6));
			end
			// every third phase the sender waits for the pipeline to empty
			if (phase % 3 == 2)
				drain();
			phase++;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && open_count == 0) begin
			$display("lru_keyed_cache_top_tb passed");
		end else begin
			$display("lru_keyed_cache_top_tb failed");
		end
		$finish;
	end

endmodule
